>>> rtl/csbf_pkg.sv
package csbf_pkg;

    localparam int MAX_TOUCHES_DEF = 8;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_AREA_TOP    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_AREA_BOTTOM = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_X_MIN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_X_MAX = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ENTER_DELAY = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_LEAVE_DELAY = 3'd5;

    localparam logic [15:0] AREA_TOP_RST    = 16'd0;
    localparam logic [15:0] AREA_BOTTOM_RST = 16'd65535;
    localparam logic [15:0] RIGHT_X_MIN_RST = 16'd32768;
    localparam logic [15:0] RIGHT_X_MAX_RST = 16'd65535;
    localparam logic [15:0] ENTER_DELAY_RST = 16'd100;
    localparam logic [15:0] LEAVE_DELAY_RST = 16'd300;

    localparam logic       FUNC_SLOT  = 1'b0;
    localparam logic       FUNC_TIMER = 1'b1;
    localparam logic [1:0] PHASE_NONE    = 2'd0;
    localparam logic [1:0] PHASE_PRESENT = 2'd1;
    localparam logic [1:0] PHASE_ENDED   = 2'd2;

    typedef enum logic [3:0] {
        BS_NONE          = 4'd0,
        BS_AREA          = 4'd1,
        BS_LEFT          = 4'd2,
        BS_LEFT_NEW      = 4'd3,
        BS_RIGHT         = 4'd4,
        BS_RIGHT_NEW     = 4'd5,
        BS_L2A           = 4'd6,
        BS_R2A           = 4'd7,
        BS_L2R           = 4'd8,
        BS_R2L           = 4'd9,
        BS_PRESSED_RIGHT = 4'd10,
        BS_PRESSED_LEFT  = 4'd11
    } t_bstate;

    typedef enum logic [2:0] {
        EV_IN_R     = 3'd0,
        EV_IN_L     = 3'd1,
        EV_IN_AREA  = 3'd2,
        EV_UP       = 3'd3,
        EV_PRESS    = 3'd4,
        EV_RELEASE  = 3'd5,
        EV_TIMEOUT  = 3'd6
    } t_ev;

    typedef enum logic [1:0] {
        CS_IDLE = 2'd0,
        CS_SLOT = 2'd1,
        CS_WALK = 2'd2,
        CS_FIN  = 2'd3
    } t_ctrl_state;

    typedef struct packed {
        logic        func;
        logic [2:0]  slot;
        logic [1:0]  touch_phase;
        logic        moved;
        logic [15:0] pos_x;
        logic [15:0] pos_y;
        logic        press_queued;
        logic        release_queued;
        logic        frame_end;
        logic [31:0] now_ms;
    } t_in_item;

    typedef struct packed {
        logic [3:0]  slot_state;
        logic        pointer_touch;
        logic        release_valid;
        logic        release_is_right;
        logic        press_valid;
        logic        press_is_right;
        logic        deadline_valid;
        logic [31:0] deadline_ms;
    } t_out_item;

    typedef struct packed {
        logic accept;
        logic slot_step;
        logic walk_step;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic is_timer;
        logic walk_last;
        logic out_free;
    } t_dp_stat;

    typedef struct packed {
        t_bstate     st;
        logic [31:0] dl;
    } t_step;

    // One transition of a slot's button machine; keep is the current deadline.
    function automatic t_step bs_next(t_bstate st, t_ev ev, logic [31:0] keep,
                                      logic [31:0] enter, logic [31:0] leave);
        t_step r;
        r.st = st;
        r.dl = keep;
        case (st)
            BS_NONE: begin
                if (ev == EV_IN_R)         r = '{BS_RIGHT_NEW, enter};
                else if (ev == EV_IN_L)    r = '{BS_LEFT_NEW, enter};
                else if (ev == EV_IN_AREA) r = '{BS_AREA, keep};
            end
            BS_AREA: begin
                r.dl = '0;
                if (ev == EV_UP)         r = '{BS_NONE, 32'd0};
                else if (ev == EV_PRESS) r = '{BS_PRESSED_LEFT, 32'd0};
            end
            BS_LEFT: begin
                r.dl = '0;
                if (ev == EV_IN_R)         r = '{BS_L2R, leave};
                else if (ev == EV_IN_AREA) r = '{BS_L2A, leave};
                else if (ev == EV_UP)      r = '{BS_NONE, 32'd0};
                else if (ev == EV_PRESS)   r = '{BS_PRESSED_LEFT, 32'd0};
            end
            BS_LEFT_NEW: begin
                if (ev == EV_IN_R)           r = '{BS_RIGHT_NEW, enter};
                else if (ev == EV_IN_AREA)   r = '{BS_L2A, 32'd0};
                else if (ev == EV_UP)        r = '{BS_NONE, 32'd0};
                else if (ev == EV_PRESS)     r = '{BS_PRESSED_LEFT, 32'd0};
                else if (ev == EV_TIMEOUT)   r = '{BS_LEFT, keep};
            end
            BS_RIGHT: begin
                r.dl = '0;
                if (ev == EV_IN_L)         r = '{BS_R2L, leave};
                else if (ev == EV_IN_AREA) r = '{BS_R2A, leave};
                else if (ev == EV_UP)      r = '{BS_NONE, 32'd0};
                else if (ev == EV_PRESS)   r = '{BS_PRESSED_RIGHT, 32'd0};
            end
            BS_RIGHT_NEW: begin
                if (ev == EV_IN_L)           r = '{BS_LEFT_NEW, enter};
                else if (ev == EV_IN_AREA)   r = '{BS_AREA, 32'd0};
                else if (ev == EV_UP)        r = '{BS_NONE, 32'd0};
                else if (ev == EV_PRESS)     r = '{BS_PRESSED_RIGHT, 32'd0};
                else if (ev == EV_TIMEOUT)   r = '{BS_RIGHT, keep};
            end
            BS_L2A: begin
                if (ev == EV_IN_R)           r = '{BS_L2R, leave};
                else if (ev == EV_IN_L)      r = '{BS_LEFT, 32'd0};
                else if (ev == EV_UP)        r = '{BS_NONE, 32'd0};
                else if (ev == EV_PRESS)     r = '{BS_PRESSED_LEFT, 32'd0};
                else if (ev == EV_TIMEOUT)   r = '{BS_AREA, keep};
            end
            BS_R2A: begin
                if (ev == EV_IN_R)           r = '{BS_RIGHT, 32'd0};
                else if (ev == EV_IN_L)      r = '{BS_R2L, leave};
                else if (ev == EV_UP)        r = '{BS_NONE, 32'd0};
                else if (ev == EV_PRESS)     r = '{BS_PRESSED_RIGHT, 32'd0};
                else if (ev == EV_TIMEOUT)   r = '{BS_AREA, keep};
            end
            BS_L2R: begin
                if (ev == EV_IN_L)           r = '{BS_LEFT, 32'd0};
                else if (ev == EV_IN_AREA)   r = '{BS_L2A, leave};
                else if (ev == EV_UP)        r = '{BS_NONE, 32'd0};
                else if (ev == EV_PRESS)     r = '{BS_PRESSED_LEFT, 32'd0};
                else if (ev == EV_TIMEOUT)   r = '{BS_RIGHT, keep};
            end
            BS_R2L: begin
                if (ev == EV_IN_R)           r = '{BS_RIGHT, 32'd0};
                else if (ev == EV_IN_AREA)   r = '{BS_R2A, leave};
                else if (ev == EV_UP)        r = '{BS_NONE, 32'd0};
                else if (ev == EV_PRESS)     r = '{BS_PRESSED_RIGHT, 32'd0};
                else if (ev == EV_TIMEOUT)   r = '{BS_LEFT, keep};
            end
            BS_PRESSED_RIGHT, BS_PRESSED_LEFT: begin
                r.dl = '0;
                if (ev == EV_RELEASE) r = '{BS_NONE, 32'd0};
            end
            default: begin
                r.st = st;
                r.dl = keep;
            end
        endcase
        return r;
    endfunction

endpackage

>>> rtl/csbf_ctrl.sv
module csbf_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  csbf_pkg::t_dp_stat i_stat,
    output csbf_pkg::t_dp_cmd  o_cmd
);
    import csbf_pkg::*;

    t_ctrl_state r_state;
    t_ctrl_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= CS_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            CS_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = CS_SLOT;
                end
            end
            CS_SLOT: begin
                // timer checks walk the slots, reports update one slot
                if (i_stat.is_timer) begin
                    n_state = CS_WALK;
                end else begin
                    o_cmd.slot_step = 1'b1;
                    n_state         = CS_FIN;
                end
            end
            CS_WALK: begin
                o_cmd.walk_step = 1'b1;
                if (i_stat.walk_last) begin
                    n_state = CS_FIN;
                end
            end
            CS_FIN: begin
                // hold the result until the output register frees up
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = CS_IDLE;
                end
            end
            default: begin
                n_state = CS_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/csbf_dp.sv
module csbf_dp #(
    parameter int MAX_TOUCHES = csbf_pkg::MAX_TOUCHES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  csbf_pkg::t_in_item            i_in_data,
    input  logic                          i_cfg_we,
    input  logic [csbf_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [csbf_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  csbf_pkg::t_dp_cmd             i_cmd,
    output csbf_pkg::t_dp_stat            o_stat,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output csbf_pkg::t_out_item           o_out_data
);
    import csbf_pkg::*;

    localparam int IDX_W = (MAX_TOUCHES > 1) ? $clog2(MAX_TOUCHES) : 1;

    logic [15:0] r_area_top;
    logic [15:0] r_area_bottom;
    logic [15:0] r_right_x_min;
    logic [15:0] r_right_x_max;
    logic [15:0] r_enter_delay;
    logic [15:0] r_leave_delay;

    t_bstate     r_st [MAX_TOUCHES];
    logic [31:0] r_dl [MAX_TOUCHES];
    logic        r_active_right;
    logic        r_right_seen;

    t_in_item    r_item;
    logic [IDX_W-1:0] r_idx;
    logic        r_any;
    logic [31:0] r_best;
    t_out_item   r_res;
    logic        r_out_valid;
    t_out_item   r_out;

    // shared by both kinds of item
    logic [31:0] enter_dl;
    logic [31:0] leave_dl;

    // slot report
    logic [IDX_W-1:0] slot_idx;
    logic        in_range;
    logic        active;
    logic        strip;
    logic        in_right;
    logic        has_ev;
    t_ev         ev;
    t_step       s0;
    t_step       s1;
    t_step       s2;
    t_step       s3;
    logic        right_seen_nx;
    t_out_item   slot_res;

    // timer walk
    t_bstate     w_st;
    logic [31:0] w_dl;
    logic        w_expired;
    t_step       w_fire;
    t_step       w_new;
    logic        w_take;
    logic        n_any;
    logic [31:0] n_best;

    assign enter_dl = r_item.now_ms + {16'd0, r_enter_delay};
    assign leave_dl = r_item.now_ms + {16'd0, r_leave_delay};

    always_comb begin
        slot_idx = IDX_W'(r_item.slot);
        in_range = 5'(r_item.slot) < 5'(MAX_TOUCHES);
        active   = in_range && (r_item.touch_phase == PHASE_PRESENT ||
                                r_item.touch_phase == PHASE_ENDED);
        strip    = r_item.pos_y >= r_area_top && r_item.pos_y <= r_area_bottom;
        in_right = strip && r_item.pos_x >= r_right_x_min &&
                   r_item.pos_x <= r_right_x_max;

        has_ev = 1'b0;
        ev     = EV_IN_AREA;
        if (r_item.touch_phase == PHASE_ENDED) begin
            has_ev = 1'b1;
            ev     = EV_UP;
        end else if (r_item.moved) begin
            has_ev = 1'b1;
            ev     = in_right ? EV_IN_R : (strip ? EV_IN_L : EV_IN_AREA);
        end

        // touch event, then queued release, then queued press
        s0.st = r_st[slot_idx];
        s0.dl = r_dl[slot_idx];
        s1 = has_ev ? bs_next(s0.st, ev, s0.dl, enter_dl, leave_dl) : s0;
        s2 = r_item.release_queued ?
             bs_next(s1.st, EV_RELEASE, s1.dl, enter_dl, leave_dl) : s1;
        s3 = r_item.press_queued ?
             bs_next(s2.st, EV_PRESS, s2.dl, enter_dl, leave_dl) : s2;

        right_seen_nx = r_right_seen || (active && s3.st == BS_PRESSED_RIGHT);

        slot_res = '0;
        if (in_range) begin
            slot_res.slot_state    = active ? s3.st : s0.st;
            slot_res.pointer_touch = slot_res.slot_state == BS_AREA;
        end
        if (r_item.frame_end) begin
            slot_res.release_valid    = r_item.release_queued;
            slot_res.release_is_right = r_item.release_queued && r_active_right;
            slot_res.press_valid      = r_item.press_queued;
            slot_res.press_is_right   = r_item.press_queued && right_seen_nx;
        end
    end

    always_comb begin
        w_st      = r_st[r_idx];
        w_dl      = r_dl[r_idx];
        w_expired = w_dl != 32'd0 && w_dl <= r_item.now_ms;
        w_fire    = bs_next(w_st, EV_TIMEOUT, 32'd0, enter_dl, leave_dl);
        w_new.st  = w_st;
        w_new.dl  = w_dl;
        if (w_expired) begin
            w_new = w_fire;
        end
        w_take    = w_new.dl != 32'd0 && (!r_any || w_new.dl < r_best);
        n_any     = r_any || w_take;
        n_best    = w_take ? w_new.dl : r_best;
    end

    assign o_stat.is_timer  = r_item.func == FUNC_TIMER;
    assign o_stat.walk_last = r_idx == IDX_W'(MAX_TOUCHES - 1);
    assign o_stat.out_free  = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_area_top    <= AREA_TOP_RST;
            r_area_bottom <= AREA_BOTTOM_RST;
            r_right_x_min <= RIGHT_X_MIN_RST;
            r_right_x_max <= RIGHT_X_MAX_RST;
            r_enter_delay <= ENTER_DELAY_RST;
            r_leave_delay <= LEAVE_DELAY_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_AREA_TOP:    r_area_top    <= i_cfg_data;
                CFG_AREA_BOTTOM: r_area_bottom <= i_cfg_data;
                CFG_RIGHT_X_MIN: r_right_x_min <= i_cfg_data;
                CFG_RIGHT_X_MAX: r_right_x_max <= i_cfg_data;
                CFG_ENTER_DELAY: r_enter_delay <= i_cfg_data;
                CFG_LEAVE_DELAY: r_leave_delay <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_TOUCHES; i++) begin
                r_st[i] <= BS_NONE;
                r_dl[i] <= '0;
            end
            r_active_right <= 1'b0;
            r_right_seen   <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cmd.slot_step) begin
                if (active) begin
                    r_st[slot_idx] <= s3.st;
                    r_dl[slot_idx] <= s3.dl;
                end
                if (r_item.frame_end) begin
                    r_right_seen <= 1'b0;
                    if (r_item.press_queued) begin
                        r_active_right <= right_seen_nx;
                    end
                end else begin
                    r_right_seen <= right_seen_nx;
                end
            end
            if (i_cmd.walk_step) begin
                r_st[r_idx] <= w_new.st;
                r_dl[r_idx] <= w_new.dl;
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_item <= i_in_data;
            r_idx  <= '0;
            r_any  <= 1'b0;
            r_best <= '0;
        end
        if (i_cmd.slot_step) begin
            r_res <= slot_res;
        end
        if (i_cmd.walk_step) begin
            r_idx  <= r_idx + IDX_W'(1);
            r_any  <= n_any;
            r_best <= n_best;
            r_res  <= '{deadline_valid: n_any, deadline_ms: n_best, default: '0};
        end
        if (i_cmd.load_out) begin
            r_out <= r_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

>>> rtl/clickpad_soft_button_fsm.sv
// Channel   Direction  Handshake                   Beat
// in        input      i_in_valid / o_in_ready     csbf_pkg::t_in_item
// out       output     o_out_valid / i_out_ready   csbf_pkg::t_out_item
// cfg       input      i_cfg_we (no wait)          i_cfg_idx, i_cfg_data
//
// A slot report goes through the SLOT and FIN states from accept to a loaded
// result; a timer check goes through SLOT, WALK (one slot per cycle) and FIN.
// One item is in work at a time; the next is accepted once the result sits
// in the output register, which holds it while i_out_ready is low.
// Synchronous active-low reset clears all slots to NONE with no timer.
module clickpad_soft_button_fsm #(
    parameter int MAX_TOUCHES = csbf_pkg::MAX_TOUCHES_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  csbf_pkg::t_in_item              i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output csbf_pkg::t_out_item             o_out_data,
    input  logic                            i_cfg_we,
    input  logic [csbf_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [csbf_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import csbf_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    csbf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    csbf_dp #(
        .MAX_TOUCHES (MAX_TOUCHES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

>>> rtl/csbf_chk.sv
module csbf_chk (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_in_valid,
    input logic                            o_in_ready,
    input csbf_pkg::t_in_item              i_in_data,
    input logic                            o_out_valid,
    input logic                            i_out_ready,
    input csbf_pkg::t_out_item             o_out_data,
    input logic                            i_cfg_we,
    input logic [csbf_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input logic [csbf_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import csbf_pkg::*;

    // a stalled result beat stays up
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result beat dropped while stalled");

    // one item in work at a time
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input taken twice in a row");

    a_deadline_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.deadline_valid |-> o_out_data.deadline_ms == 32'd0)
        else $error("deadline shown without a pending timer");

    a_timer_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.deadline_valid |->
            o_out_data.slot_state == 4'd0 && !o_out_data.release_valid &&
            !o_out_data.press_valid)
        else $error("timer result carries slot fields");

    a_pointer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.pointer_touch == (o_out_data.slot_state == BS_AREA))
        else $error("pointer flag disagrees with slot state");

endmodule

bind clickpad_soft_button_fsm csbf_chk u_csbf_chk (.*);

>>> tb/sv/clickpad_soft_button_fsm_tb.sv
`timescale 1ns / 1ps

module clickpad_soft_button_fsm_tb;
    import csbf_pkg::*;

    localparam int PADS = MAX_TOUCHES_DEF;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    t_in_item    i_in_data;
    logic        o_out_valid;
    logic        i_out_ready;
    t_out_item   o_out_data;
    logic        i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    clickpad_soft_button_fsm u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    // Predictor state and register copies
    logic [15:0] cfg_top, cfg_bottom, cfg_xmin, cfg_xmax, cfg_enter, cfg_leave;
    t_bstate     pad_state [PADS];
    logic [31:0] pad_deadline [PADS];
    logic        active_right;
    logic        right_pressed_seen;

    t_out_item   pending_beats [$];

    typedef struct {
        bit                    is_cfg;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] val;
        t_in_item              item;
        bit                    typed;
        t_out_item             want;
    } t_row;
    t_row script [$];

    int  fails;
    int  n_items, n_ticks, n_beats_out, n_writes;
    bit  calm;
    bit  in_flight;

    function automatic void pad_event(int s, t_ev ev, logic [31:0] now);
        logic [31:0] enter_dl;
        logic [31:0] leave_dl;
        logic [31:0] dl;
        logic [3:0]  nxt;
        t_bstate     cur;
        bit          on_right;
        enter_dl = now + cfg_enter;
        leave_dl = now + cfg_leave;
        cur = pad_state[s];
        nxt = cur;
        dl = pad_deadline[s];
        on_right = 1'b0;
        case (cur)
            BS_AREA, BS_LEFT, BS_RIGHT, BS_PRESSED_LEFT, BS_PRESSED_RIGHT: dl = '0;
            default: ;
        endcase
        case (cur)
            BS_NONE: begin
                case (ev)
                    EV_IN_R:    {nxt, dl} = {BS_RIGHT_NEW, enter_dl};
                    EV_IN_L:    {nxt, dl} = {BS_LEFT_NEW, enter_dl};
                    EV_IN_AREA: nxt = BS_AREA;
                    default: ;
                endcase
            end
            BS_LEFT: begin
                case (ev)
                    EV_IN_R:    {nxt, dl} = {BS_L2R, leave_dl};
                    EV_IN_AREA: {nxt, dl} = {BS_L2A, leave_dl};
                    default: ;
                endcase
            end
            BS_LEFT_NEW: begin
                case (ev)
                    EV_IN_R:    {nxt, dl} = {BS_RIGHT_NEW, enter_dl};
                    EV_IN_AREA: {nxt, dl} = {BS_L2A, 32'd0};
                    EV_TIMEOUT: nxt = BS_LEFT;
                    default: ;
                endcase
            end
            BS_RIGHT: begin
                on_right = 1'b1;
                case (ev)
                    EV_IN_L:    {nxt, dl} = {BS_R2L, leave_dl};
                    EV_IN_AREA: {nxt, dl} = {BS_R2A, leave_dl};
                    default: ;
                endcase
            end
            BS_RIGHT_NEW: begin
                on_right = 1'b1;
                case (ev)
                    EV_IN_L:    {nxt, dl} = {BS_LEFT_NEW, enter_dl};
                    EV_IN_AREA: {nxt, dl} = {BS_AREA, 32'd0};
                    EV_TIMEOUT: nxt = BS_RIGHT;
                    default: ;
                endcase
            end
            BS_L2A: begin
                case (ev)
                    EV_IN_R:    {nxt, dl} = {BS_L2R, leave_dl};
                    EV_IN_L:    {nxt, dl} = {BS_LEFT, 32'd0};
                    EV_TIMEOUT: nxt = BS_AREA;
                    default: ;
                endcase
            end
            BS_R2A: begin
                on_right = 1'b1;
                case (ev)
                    EV_IN_R:    {nxt, dl} = {BS_RIGHT, 32'd0};
                    EV_IN_L:    {nxt, dl} = {BS_R2L, leave_dl};
                    EV_TIMEOUT: nxt = BS_AREA;
                    default: ;
                endcase
            end
            BS_L2R: begin
                case (ev)
                    EV_IN_L:    {nxt, dl} = {BS_LEFT, 32'd0};
                    EV_IN_AREA: {nxt, dl} = {BS_L2A, leave_dl};
                    EV_TIMEOUT: nxt = BS_RIGHT;
                    default: ;
                endcase
            end
            BS_R2L: begin
                on_right = 1'b1;
                case (ev)
                    EV_IN_R:    {nxt, dl} = {BS_RIGHT, 32'd0};
                    EV_IN_AREA: {nxt, dl} = {BS_R2A, leave_dl};
                    EV_TIMEOUT: nxt = BS_LEFT;
                    default: ;
                endcase
            end
            BS_PRESSED_LEFT, BS_PRESSED_RIGHT: begin
                if (ev == EV_RELEASE) {nxt, dl} = {BS_NONE, 32'd0};
            end
            default: ;
        endcase
        // lift and click act alike on every touching, unpressed state
        if (cur != BS_NONE && cur != BS_PRESSED_LEFT && cur != BS_PRESSED_RIGHT) begin
            if (ev == EV_UP)
                {nxt, dl} = {BS_NONE, 32'd0};
            else if (ev == EV_PRESS)
                {nxt, dl} = {on_right ? BS_PRESSED_RIGHT : BS_PRESSED_LEFT, 32'd0};
        end
        pad_state[s] = t_bstate'(nxt);
        pad_deadline[s] = dl;
    endfunction

    function automatic t_out_item predict_beat(t_in_item it);
        t_out_item   o;
        bit          any;
        logic [31:0] best;
        logic        strip;
        logic        in_right;
        o = '0;
        if (it.func == FUNC_TIMER) begin
            any = 1'b0;
            best = '0;
            for (int j = 0; j < PADS; j++) begin
                if (pad_deadline[j] != 0 && pad_deadline[j] <= it.now_ms) begin
                    pad_deadline[j] = '0;
                    pad_event(j, EV_TIMEOUT, it.now_ms);
                end
                if (pad_deadline[j] != 0 && (!any || pad_deadline[j] < best)) begin
                    best = pad_deadline[j];
                    any = 1'b1;
                end
            end
            o.deadline_valid = any;
            o.deadline_ms = best;
            return o;
        end
        if (it.touch_phase == PHASE_PRESENT || it.touch_phase == PHASE_ENDED) begin
            if (it.touch_phase == PHASE_ENDED) begin
                pad_event(it.slot, EV_UP, it.now_ms);
            end else if (it.moved) begin
                strip = it.pos_y >= cfg_top && it.pos_y <= cfg_bottom;
                in_right = strip && it.pos_x >= cfg_xmin && it.pos_x <= cfg_xmax;
                pad_event(it.slot, in_right ? EV_IN_R : (strip ? EV_IN_L : EV_IN_AREA),
                          it.now_ms);
            end
            if (it.release_queued) pad_event(it.slot, EV_RELEASE, it.now_ms);
            if (it.press_queued) pad_event(it.slot, EV_PRESS, it.now_ms);
            if (pad_state[it.slot] == BS_PRESSED_RIGHT) right_pressed_seen = 1'b1;
        end
        o.slot_state = pad_state[it.slot];
        o.pointer_touch = (pad_state[it.slot] == BS_AREA);
        if (it.frame_end) begin
            if (it.release_queued) begin
                o.release_valid = 1'b1;
                o.release_is_right = active_right;
            end
            if (it.press_queued) begin
                o.press_valid = 1'b1;
                o.press_is_right = right_pressed_seen;
                active_right = right_pressed_seen;
            end
            right_pressed_seen = 1'b0;
        end
        return o;
    endfunction

    function automatic t_in_item rep(logic [2:0] slot, logic [1:0] phase, logic moved,
                                     logic [15:0] x, logic [15:0] y, logic press,
                                     logic rel, logic fend, logic [31:0] now);
        t_in_item it;
        it = '0;
        it.func = FUNC_SLOT;
        it.slot = slot;
        it.touch_phase = phase;
        it.moved = moved;
        it.pos_x = x;
        it.pos_y = y;
        it.press_queued = press;
        it.release_queued = rel;
        it.frame_end = fend;
        it.now_ms = now;
        return it;
    endfunction

    function automatic t_in_item tick(logic [31:0] now);
        t_in_item it;
        it = '0;
        it.func = FUNC_TIMER;
        it.now_ms = now;
        return it;
    endfunction

    function automatic string fmt_beat(t_out_item b);
        return $sformatf("st=%0d pt=%b rel=%b/%b prs=%b/%b dl=%b/%08h", b.slot_state,
                         b.pointer_touch, b.release_valid, b.release_is_right,
                         b.press_valid, b.press_is_right, b.deadline_valid, b.deadline_ms);
    endfunction

    function automatic void note_fail(string msg);
        fails++;
        if (fails <= 10) $display("%s", msg);
    endfunction

    function automatic void add_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        t_row r;
        r = '{default: '0};
        r.is_cfg = 1'b1;
        r.idx = idx;
        r.val = val;
        script.push_back(r);
    endfunction

    function automatic void add_item(t_in_item it, bit typed = 1'b0, t_out_item want = '0);
        t_row r;
        r = '{default: '0};
        r.item = it;
        r.typed = typed;
        r.want = want;
        script.push_back(r);
    endfunction

    task automatic send_item(t_in_item it, bit typed = 1'b0, t_out_item want = '0);
        t_out_item exp_beat;
        @(negedge i_clk);
        while (!calm && $urandom_range(99) < 35) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= it;
        do @(posedge i_clk); while (!o_in_ready);
        exp_beat = predict_beat(it);
        pending_beats.push_back(typed ? want : exp_beat);
        in_flight = 1'b1;
        n_items++;
        if (it.func == FUNC_TIMER) n_ticks++;
        calm = (n_items >= 700 && n_items < 1000);
    endtask

    task automatic drain_to_idle();
        int spins;
        spins = 0;
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_beats.size() != 0 && spins < 5000) begin
            @(posedge i_clk);
            spins++;
        end
        if (pending_beats.size() != 0) begin
            note_fail($sformatf("%0d expected beats never arrived", pending_beats.size()));
            fails += pending_beats.size() - 1;
            pending_beats.delete();
        end
        // let a timer walk still in progress finish
        repeat (16) @(posedge i_clk);
        in_flight = 1'b0;
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_AREA_TOP:    cfg_top = val;
            CFG_AREA_BOTTOM: cfg_bottom = val;
            CFG_RIGHT_X_MIN: cfg_xmin = val;
            CFG_RIGHT_X_MAX: cfg_xmax = val;
            CFG_ENTER_DELAY: cfg_enter = val;
            CFG_LEAVE_DELAY: cfg_leave = val;
            default: ;
        endcase
        n_writes++;
    endtask

    task automatic set_config(logic [15:0] top, logic [15:0] bottom, logic [15:0] xmin,
                              logic [15:0] xmax, logic [15:0] enter, logic [15:0] leave);
        write_reg(CFG_AREA_TOP, top);
        write_reg(CFG_AREA_BOTTOM, bottom);
        write_reg(CFG_RIGHT_X_MIN, xmin);
        write_reg(CFG_RIGHT_X_MAX, xmax);
        write_reg(CFG_ENTER_DELAY, enter);
        write_reg(CFG_LEAVE_DELAY, leave);
    endtask

    always @(negedge i_clk) begin
        i_out_ready <= calm || ($urandom_range(99) >= 35);
    end

    always @(posedge i_clk) begin : beat_check
        t_out_item want;
        string     bad;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            n_beats_out++;
            if (pending_beats.size() == 0) begin
                note_fail($sformatf("unexpected beat %s", fmt_beat(o_out_data)));
            end else begin
                want = pending_beats.pop_front();
                bad = "";
                if (o_out_data.slot_state !== want.slot_state) bad = {bad, " slot_state"};
                if (o_out_data.pointer_touch !== want.pointer_touch)
                    bad = {bad, " pointer_touch"};
                if (o_out_data.release_valid !== want.release_valid)
                    bad = {bad, " release_valid"};
                if (o_out_data.release_is_right !== want.release_is_right)
                    bad = {bad, " release_is_right"};
                if (o_out_data.press_valid !== want.press_valid) bad = {bad, " press_valid"};
                if (o_out_data.press_is_right !== want.press_is_right)
                    bad = {bad, " press_is_right"};
                if (o_out_data.deadline_valid !== want.deadline_valid)
                    bad = {bad, " deadline_valid"};
                if (o_out_data.deadline_ms !== want.deadline_ms) bad = {bad, " deadline_ms"};
                if (bad != "")
                    note_fail($sformatf("beat %0d:%s differ, exp %s got %s", n_beats_out, bad,
                                        fmt_beat(want), fmt_beat(o_out_data)));
            end
        end
    end

    initial begin
        #20_000_000;
        $display("simulation failed");
        $finish;
    end

    initial begin
        t_out_item   area_beat;
        t_in_item    it;
        logic [95:0] noise;
        logic [31:0] clock_ms;
        logic [15:0] top, xmin;
        int          target, nrep, zone, r, p;
        logic [1:0]  phase;
        logic        press, rel;
        logic [15:0] x, y;

        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        fails = 0;
        n_items = 0;
        n_ticks = 0;
        n_beats_out = 0;
        n_writes = 0;
        calm = 1'b0;
        in_flight = 1'b0;
        cfg_top = AREA_TOP_RST;
        cfg_bottom = AREA_BOTTOM_RST;
        cfg_xmin = RIGHT_X_MIN_RST;
        cfg_xmax = RIGHT_X_MAX_RST;
        cfg_enter = ENTER_DELAY_RST;
        cfg_leave = LEAVE_DELAY_RST;
        for (int j = 0; j < PADS; j++) begin
            pad_state[j] = BS_NONE;
            pad_deadline[j] = '0;
        end
        active_right = 1'b0;
        right_pressed_seen = 1'b0;

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        area_beat = '0;
        area_beat.slot_state = BS_AREA;
        area_beat.pointer_touch = 1'b1;

        // nothing pending after reset, untouched slot stays idle
        add_item(tick(32'd0), 1'b1, '0);
        add_item(rep(3'd0, PHASE_NONE, 1'b1, 16'hFFFF, 16'hFFFF, 1'b0, 1'b0, 1'b1, 32'd5),
                 1'b1, '0);
        // right zone, settle by timer, click and release as right button
        add_item(rep(3'd0, PHASE_PRESENT, 1'b1, 16'hFFFF, 16'h0000, 1'b0, 1'b0, 1'b0, 32'd1000));
        add_item(tick(32'd1050));
        add_item(tick(32'd1100));
        add_item(rep(3'd0, PHASE_PRESENT, 1'b0, 16'h0, 16'h0, 1'b1, 1'b0, 1'b1, 32'd1110));
        add_item(rep(3'd0, PHASE_ENDED, 1'b0, 16'h0, 16'h0, 1'b0, 1'b1, 1'b1, 32'd1120));
        add_item(rep(3'd1, PHASE_PRESENT, 1'b1, 16'h0000, 16'h8000, 1'b0, 1'b0, 1'b0, 32'd1130));
        add_item(rep(3'd1, PHASE_PRESENT, 1'b1, 16'h8000, 16'h8000, 1'b0, 1'b0, 1'b1, 32'd1140));
        // unused phase code: slot untouched, frame still reports
        add_item(rep(3'd7, 2'd3, 1'b1, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 1'b1, 32'd1150));
        // deadline wraps to zero, so no timer is armed
        add_item(rep(3'd2, PHASE_PRESENT, 1'b1, 16'h0, 16'h0, 1'b0, 1'b0, 1'b0, 32'hFFFF_FF9C));
        add_item(tick(32'hFFFF_FFFF));
        // empty strip: every move lands in the plain area
        add_cfg(CFG_AREA_TOP, 16'h8000);
        add_cfg(CFG_AREA_BOTTOM, 16'h7FFF);
        add_cfg(CFG_ENTER_DELAY, 16'd0);
        add_item(rep(3'd3, PHASE_PRESENT, 1'b1, 16'h1234, 16'h5678, 1'b0, 1'b0, 1'b1, 32'd2000),
                 1'b1, area_beat);
        add_item(rep(3'd3, PHASE_PRESENT, 1'b0, 16'h0, 16'h0, 1'b1, 1'b0, 1'b1, 32'd2010));
        add_item(rep(3'd3, PHASE_PRESENT, 1'b1, 16'h0, 16'h0, 1'b0, 1'b1, 1'b1, 32'd2020));
        add_cfg(CFG_AREA_TOP, 16'h0000);
        add_cfg(CFG_AREA_BOTTOM, 16'hFFFF);
        add_cfg(CFG_RIGHT_X_MIN, 16'h4000);
        add_cfg(CFG_RIGHT_X_MAX, 16'hC000);
        add_cfg(CFG_ENTER_DELAY, 16'hFFFF);
        add_cfg(CFG_LEAVE_DELAY, 16'h0000);
        add_item(rep(3'd4, PHASE_PRESENT, 1'b1, 16'h4000, 16'hFFFF, 1'b0, 1'b0, 1'b0, 32'd3000));
        add_item(rep(3'd4, PHASE_PRESENT, 1'b1, 16'hC001, 16'h0000, 1'b0, 1'b0, 1'b0, 32'd3010));
        add_item(rep(3'd5, PHASE_PRESENT, 1'b1, 16'hC000, 16'h0000, 1'b0, 1'b0, 1'b1, 32'd3020));
        add_item(tick(32'd70000));
        // left move while settled left: no transition, no timer armed
        add_item(rep(3'd4, PHASE_PRESENT, 1'b1, 16'hFFFF, 16'h0, 1'b0, 1'b0, 1'b0, 32'd70010));
        add_item(rep(3'd5, PHASE_PRESENT, 1'b1, 16'h0000, 16'h0, 1'b0, 1'b0, 1'b1, 32'd70020));
        add_item(rep(3'd4, PHASE_ENDED, 1'b0, 16'h0, 16'h0, 1'b0, 1'b0, 1'b1, 32'd70030));
        add_item(tick(32'd70020));
        add_item(rep(3'd6, PHASE_ENDED, 1'b0, 16'h0, 16'h0, 1'b1, 1'b0, 1'b1, 32'd70040));
        add_item(tick(32'hFFFF_FFFF));

        foreach (script[k]) begin
            if (script[k].is_cfg) begin
                if (in_flight) drain_to_idle();
                write_reg(script[k].idx, script[k].val);
            end else begin
                send_item(script[k].item, script[k].typed, script[k].want);
            end
        end

        clock_ms = 32'd100000;
        for (int ph = 0; ph < 6; ph++) begin
            drain_to_idle();
            case (ph)
                0: set_config(16'h1000, 16'hE000, 16'h8000, 16'hFFFF, 16'd100, 16'd300);
                1: set_config(16'h0000, 16'hFFFF, 16'h0000, 16'h7FFF, 16'd0, 16'd0);
                2: set_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
                3: set_config(16'h8000, 16'h7FFF, 16'h0000, 16'h0000, 16'd1, 16'd2);
                default: begin
                    top = 16'($urandom_range(16'h7FFF));
                    xmin = 16'($urandom_range(16'hFFFF));
                    set_config(top, 16'($urandom_range(16'hFFFF, top)), xmin,
                               16'($urandom_range(16'hFFFF, xmin)), 16'($urandom_range(400)),
                               16'($urandom_range(600)));
                end
            endcase
            // cross the 32-bit wrap of the millisecond clock once
            if (ph == 4) clock_ms = 32'hFFFF_F000;
            target = n_items + 275;
            while (n_items < target) begin
                if ($urandom_range(99) < 12) begin
                    noise = {$urandom, $urandom, $urandom};
                    send_item(t_in_item'(noise[$bits(t_in_item)-1:0]));
                    continue;
                end
                nrep = $urandom_range(4, 1);
                press = ($urandom_range(99) < 15);
                rel = ($urandom_range(99) < 15);
                clock_ms += ($urandom_range(99) < 8) ? $urandom_range(70000)
                                                      : $urandom_range(40);
                for (r = 0; r < nrep; r++) begin
                    p = $urandom_range(99);
                    phase = (p < 88) ? PHASE_PRESENT : (p < 96) ? PHASE_ENDED :
                            (p < 98) ? PHASE_NONE : 2'd3;
                    zone = $urandom_range(2);
                    y = (zone < 2) ? 16'($urandom_range(cfg_bottom, cfg_top)) : 16'($urandom);
                    x = (zone == 0) ? 16'($urandom_range(cfg_xmax, cfg_xmin)) : 16'($urandom);
                    it = rep(3'($urandom_range(7)), phase, ($urandom_range(99) < 85), x, y,
                             press, rel, (r == nrep - 1), clock_ms);
                    send_item(it);
                end
                if ($urandom_range(99) < 40) begin
                    clock_ms += $urandom_range(200);
                    send_item(tick(clock_ms));
                end
            end
        end

        drain_to_idle();
        $display("%0d items sent (%0d timer checks), %0d beats checked, %0d register writes",
                 n_items, n_ticks, n_beats_out, n_writes);
        $display("%0d mismatches over six register settings plus the directed table", fails);
        if (fails == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
